// ===== src/sgid_pkg.sv =====
// ----------------------------------------------------------------------------
// sgid_pkg
// Shared types and constants of the Shift-JIS glyph index decoder: pen limits,
// the absent glyph range table and the structs passed between stages.
// ----------------------------------------------------------------------------
package sgid_pkg;

    // screen and pen limits
    localparam int SCREEN_X_LIMIT = 1023;
    localparam logic [9:0] PEN_CAP =
        (SCREEN_X_LIMIT > 1023) ? 10'd1023 : 10'(SCREEN_X_LIMIT);
    localparam logic [3:0] HALF_ADVANCE = 4'd5;
    localparam logic [3:0] FULL_ADVANCE = 4'd10;

    // largest full-width glyph index
    localparam logic [13:0] GLYPH_MAX = 14'd8835;

    // shift-jis conversion constants
    localparam logic [15:0] SJIS_HIGH_BLOCK = 16'hE000;
    localparam logic [15:0] SJIS_HIGH_SHIFT = 16'h4000;
    localparam logic [7:0]  SJIS_LEAD_BASE  = 8'h81;
    localparam logic [7:0]  SJIS_ODD_SPLIT  = 8'h9E;
    localparam logic [15:0] SJIS_EVEN_ADD   = 16'h0062;
    localparam logic [15:0] SJIS_ODD_SUB    = 16'h0040;
    localparam logic [15:0] EUC_OFFSET      = 16'hA1A1;
    localparam logic [7:0]  EUC_BASE        = 8'hA1;
    localparam logic [6:0]  EUC_ROW_CELLS   = 7'd94;

    // absent glyph ranges: first code, last code, glyphs skipped up to and including this range
    localparam int GAP_COUNT = 18;
    localparam logic [15:0] GAP_FIRST [GAP_COUNT] = '{
        16'hA2AF, 16'hA2C2, 16'hA2D1, 16'hA2EB, 16'hA2FA, 16'hA3A1,
        16'hA3BA, 16'hA3DB, 16'hA3FB, 16'hA4F4, 16'hA5F7, 16'hA6B9,
        16'hA6D9, 16'hA7C2, 16'hA7F2, 16'hA8C1, 16'hCFD4, 16'hF4A5
    };
    localparam logic [15:0] GAP_LAST [GAP_COUNT] = '{
        16'hA2B9, 16'hA2C9, 16'hA2DB, 16'hA2F1, 16'hA2FD, 16'hA3AF,
        16'hA3C0, 16'hA3E0, 16'hA3FE, 16'hA4FE, 16'hA5FE, 16'hA6C0,
        16'hA6FE, 16'hA7D0, 16'hA7FE, 16'hAB90, 16'hCFFE, 16'hF8AA
    };
    localparam logic [10:0] GAP_SKIP [GAP_COUNT] = '{
        11'd11,  11'd19,  11'd30,  11'd37,  11'd41,  11'd56,
        11'd63,  11'd69,  11'd73,  11'd84,  11'd92,  11'd100,
        11'd138, 11'd153, 11'd166, 11'd886, 11'd929, 11'd1959
    };

    // one decoded character waiting for glyph lookup
    typedef struct packed {
        logic       full;
        logic [7:0] lead;
        logic [7:0] text;
        logic [9:0] pen;
    } sgid_item_t;

    // one result transaction
    typedef struct packed {
        logic [13:0] glyph_index;
        logic        full_width;
        logic        missing_glyph;
        logic [9:0]  pen_x;
    } sgid_result_t;

endpackage

// ===== src/sgid_front.sv =====
// ----------------------------------------------------------------------------
// sgid_front
// Byte classifier and input register: keeps the pending lead byte and pen
// position, and registers each character that produces a glyph.
// ----------------------------------------------------------------------------
module sgid_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_text_byte,
    input  logic                s_string_start,
    input  logic [9:0]          s_start_x,
    output logic                item_valid,
    input  logic                item_ready,
    output sgid_pkg::sgid_item_t item
);
    import sgid_pkg::*;

    typedef enum logic [1:0] {
        CLS_END,
        CLS_PAIR,
        CLS_LEAD,
        CLS_HALF
    } byte_class_t;

    logic [7:0]  lead_reg, lead_next;
    logic [9:0]  pen_reg, pen_next;
    logic        item_valid_reg, item_valid_next;
    sgid_item_t  item_reg, item_next;

    logic        accept;
    logic [7:0]  lead_base;
    logic [9:0]  pen_base;
    logic [3:0]  pen_step;
    logic [10:0] pen_sum;
    logic [9:0]  pen_adv;
    byte_class_t byte_class;

    assign s_ready    = !item_valid_reg || item_ready;
    assign accept     = s_valid && s_ready;
    assign item_valid = item_valid_reg;
    assign item       = item_reg;

    // string start reloads the pen and drops a held lead byte
    always_comb begin
        lead_base = s_string_start ? 8'h00 : lead_reg;
        if (s_string_start) begin
            pen_base = (s_start_x > PEN_CAP) ? PEN_CAP : s_start_x;
        end else begin
            pen_base = pen_reg;
        end
    end

    // classify the byte against the held lead
    always_comb begin
        if (s_text_byte == 8'h00) begin
            byte_class = CLS_END;
        end else if (lead_base != 8'h00) begin
            byte_class = CLS_PAIR;
        end else if ((s_text_byte >= 8'h80 && s_text_byte < 8'hA0) || s_text_byte >= 8'hE0) begin
            byte_class = CLS_LEAD;
        end else begin
            byte_class = CLS_HALF;
        end
    end

    // saturating pen advance
    always_comb begin
        pen_step = (byte_class == CLS_PAIR) ? FULL_ADVANCE : HALF_ADVANCE;
        pen_sum  = {1'b0, pen_base} + {7'd0, pen_step};
        pen_adv  = (pen_sum > {1'b0, PEN_CAP}) ? PEN_CAP : pen_sum[9:0];
    end

    // next state and stage register
    always_comb begin
        lead_next       = lead_reg;
        pen_next        = pen_reg;
        item_valid_next = item_valid_reg && !item_ready;
        item_next       = item_reg;
        if (accept) begin
            unique case (byte_class)
                CLS_END: begin
                    lead_next = 8'h00;
                    pen_next  = pen_base;
                end
                CLS_LEAD: begin
                    lead_next = s_text_byte;
                    pen_next  = pen_base;
                end
                CLS_PAIR, CLS_HALF: begin
                    lead_next       = 8'h00;
                    pen_next        = pen_adv;
                    item_valid_next = 1'b1;
                    item_next.full  = (byte_class == CLS_PAIR);
                    item_next.lead  = lead_base;
                    item_next.text  = s_text_byte;
                    item_next.pen   = pen_base;
                end
                default: begin
                    lead_next = lead_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_reg       <= 8'h00;
            pen_reg        <= 10'd0;
            item_valid_reg <= 1'b0;
        end else begin
            lead_reg       <= lead_next;
            pen_reg        <= pen_next;
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

endmodule

// ===== src/sgid_glyph.sv =====
// ----------------------------------------------------------------------------
// sgid_glyph
// Glyph lookup: half-width range offsets, or Shift-JIS to EUC-JP conversion
// followed by row/cell indexing and removal of absent glyph ranges.
// ----------------------------------------------------------------------------
module sgid_glyph (
    input  sgid_pkg::sgid_item_t   item,
    output sgid_pkg::sgid_result_t result
);
    import sgid_pkg::*;

    logic [15:0]        raw_code, c0, c1, c2, c3, euc_code;
    logic [7:0]         hi_off;
    logic               gap_hit;
    logic [10:0]        skip;
    logic signed [16:0] row, col, n_raw, n_adj;
    logic               out_of_range;
    logic [13:0]        half_index;

    // shift-jis pair to euc-jp, 16-bit wrapping
    always_comb begin
        raw_code = {item.lead, item.text};
        c0       = (raw_code >= SJIS_HIGH_BLOCK) ? raw_code - SJIS_HIGH_SHIFT : raw_code;
        hi_off   = c0[15:8] - SJIS_LEAD_BASE;
        c1       = {hi_off[6:0], 1'b0, c0[7:0]};
        c2       = c1[7] ? c1 - 16'd1 : c1;
        c3       = (c2[7:0] >= SJIS_ODD_SPLIT) ? c2 + SJIS_EVEN_ADD : c2 - SJIS_ODD_SUB;
        euc_code = c3 + EUC_OFFSET;
    end

    // absent glyph ranges: hit test and skipped count
    always_comb begin
        gap_hit = 1'b0;
        skip    = 11'd0;
        for (int k = 0; k < GAP_COUNT; k++) begin
            if (euc_code >= GAP_FIRST[k] && euc_code <= GAP_LAST[k]) begin
                gap_hit = 1'b1;
            end
            if (euc_code > GAP_LAST[k]) begin
                skip = GAP_SKIP[k];
            end
        end
    end

    // row * 94 + cell, less the skipped glyphs
    always_comb begin
        row          = $signed({9'd0, euc_code[15:8]}) - $signed({9'd0, EUC_BASE});
        col          = $signed({9'd0, euc_code[7:0]}) - $signed({9'd0, EUC_BASE});
        n_raw        = 17'(row * $signed({10'd0, EUC_ROW_CELLS})) + col;
        n_adj        = n_raw - $signed({6'd0, skip});
        out_of_range = n_adj[16] || (n_adj > $signed({3'd0, GLYPH_MAX}));
    end

    // half-width range offsets
    always_comb begin
        if (item.text < 8'h20) begin
            half_index = 14'd0;
        end else if (item.text < 8'h80) begin
            half_index = {6'd0, item.text - 8'h20};
        end else if (item.text < 8'hA0) begin
            half_index = 14'd0;
        end else begin
            half_index = {6'd0, item.text - 8'h40};
        end
    end

    // result assembly
    always_comb begin
        result.full_width = item.full;
        result.pen_x      = item.pen;
        if (item.full) begin
            result.missing_glyph = gap_hit || out_of_range;
            result.glyph_index   = (gap_hit || out_of_range) ? 14'd0 : n_adj[13:0];
        end else begin
            result.missing_glyph = 1'b0;
            result.glyph_index   = half_index;
        end
    end

endmodule

// ===== src/sjis_glyph_index_decoder.sv =====
// An accepted byte passes the input register, then the output register.
// Throughput: one byte per cycle unless m_ready stalls the output; lead and
// zero bytes give no result. The pending lead byte and pen position update
// as each byte is accepted. Reset (aresetn low, synchronous) clears the lead
// byte, the pen and both valid flags; no result is pending after reset.
// ----------------------------------------------------------------------------
// sjis_glyph_index_decoder
// Shift-JIS byte stream to half-/full-width glyph numbers with pen positions:
// input register, glyph lookup logic and output register.
// ----------------------------------------------------------------------------
module sjis_glyph_index_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_string_start,
    input  logic [9:0]  s_start_x,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [13:0] m_glyph_index,
    output logic        m_full_width,
    output logic        m_missing_glyph,
    output logic [9:0]  m_pen_x
);
    import sgid_pkg::*;

    logic         item_valid;
    logic         item_ready;
    sgid_item_t   item;
    sgid_result_t result;
    logic         out_valid_reg, out_valid_next;
    sgid_result_t out_reg, out_next;

    // byte classifier, lead/pen state and input register
    sgid_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_string_start(s_string_start),
        .s_start_x     (s_start_x),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item)
    );

    // glyph lookup
    sgid_glyph u_glyph (
        .item  (item),
        .result(result)
    );

    // output register
    assign item_ready = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        if (item_ready) begin
            out_valid_next = item_valid;
            out_next       = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_glyph_index   = out_reg.glyph_index;
    assign m_full_width    = out_reg.full_width;
    assign m_missing_glyph = out_reg.missing_glyph;
    assign m_pen_x         = out_reg.pen_x;

`ifndef SYNTHESIS
    // half-width glyphs are never flagged missing
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_full_width |-> !m_missing_glyph)
        else $error("half-width glyph flagged missing");

    // a missing glyph reports index zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_missing_glyph |-> m_glyph_index == 14'd0)
        else $error("missing glyph with non-zero index");

    // full-width index stays inside the font
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_full_width |-> m_glyph_index <= GLYPH_MAX)
        else $error("full-width index beyond font");

    // half-width index stays inside the half-width font
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_full_width |-> m_glyph_index <= 14'd159)
        else $error("half-width index beyond font");

    // a result taken from the front stage shows up the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid && item_ready |=> m_valid)
        else $error("result lost between stages");
`endif

endmodule

// ===== tb/tb_sjis_glyph_index_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_sjis_glyph_index_decoder
// Self-checking bench for the Shift-JIS glyph index decoder. A queue of text
// bytes (directed corner cases, then random strings and noise) feeds a
// valid/ready driver. Every accepted byte runs through a local decoder model
// that queues any expected glyph transaction. A monitor compares each result
// transaction field by field. Both sides idle at random, except in one quiet
// window, and the sender holds off at marked bytes until all results have drained.
// ----------------------------------------------------------------------------
module tb_sjis_glyph_index_decoder;
    import sgid_pkg::*;

    // byte classes of the shift-jis stream
    localparam logic [7:0] END_OF_STRING      = 8'h00;
    localparam logic [7:0] HALF_PRINT_FIRST   = 8'h20;
    localparam logic [7:0] LOW_LEAD_FIRST     = 8'h80;
    localparam logic [7:0] HALF_KANA_FIRST    = 8'hA0;
    localparam logic [7:0] HIGH_LEAD_FIRST    = 8'hE0;
    localparam logic [7:0] PRINT_GLYPH_OFFSET = 8'h20;
    localparam logic [7:0] KANA_GLYPH_OFFSET  = 8'h40;
    localparam logic [7:0] TRAIL_FIRST        = 8'h40;
    localparam logic [7:0] TRAIL_LAST         = 8'hFC;
    localparam logic [7:0] TRAIL_HOLE         = 8'h7F;

    localparam int RANDOM_BYTES  = 1750;
    localparam int IDLE_PERCENT  = 14;
    localparam int QUIET_FIRST   = 700;
    localparam int QUIET_LAST    = 1300;
    localparam int REPORT_LIMIT  = 40;

    typedef struct {
        logic [7:0] text;
        logic       start;
        logic [9:0] sx;
        logic       drain;
    } text_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_text_byte = '0;
    logic        s_string_start = 1'b0;
    logic [9:0]  s_start_x = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [13:0] m_glyph_index;
    logic        m_full_width;
    logic        m_missing_glyph;
    logic [9:0]  m_pen_x;

    text_byte_t   text_q[$];
    sgid_result_t glyph_q[$];
    logic [7:0]   lead_held;
    logic [9:0]   pen_pos;
    int unsigned  cycle_count = 0;
    int unsigned  error_count = 0;

    sjis_glyph_index_decoder uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_text_byte     (s_text_byte),
        .s_string_start  (s_string_start),
        .s_start_x       (s_start_x),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_glyph_index   (m_glyph_index),
        .m_full_width    (m_full_width),
        .m_missing_glyph (m_missing_glyph),
        .m_pen_x         (m_pen_x)
    );

    // clock and reset
    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // mismatch report
    task automatic report_mismatch(input string field, input int got, input int want);
        if (error_count < REPORT_LIMIT)
            $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $time);
        error_count++;
    endtask

    // lead plus trail to full-width glyph number; returns 1 when missing
    function automatic bit sjis_full_glyph(input logic [7:0] lead, input logic [7:0] trail,
                                           output logic [13:0] glyph);
        logic [15:0] code;
        logic [15:0] row;
        int          n;
        glyph = '0;
        code = {lead, trail};
        if (code >= SJIS_HIGH_BLOCK) code = code - SJIS_HIGH_SHIFT;
        row = {8'h00, code[15:8]} - {8'h00, SJIS_LEAD_BASE};
        code = (row << 9) + {8'h00, code[7:0]};
        if (code[7:0] >= LOW_LEAD_FIRST) code = code - 16'd1;
        if (code[7:0] >= SJIS_ODD_SPLIT) code = code + SJIS_EVEN_ADD;
        else code = code - SJIS_ODD_SUB;
        code = code + EUC_OFFSET;
        n = (int'(code[15:8]) - int'(EUC_BASE)) * int'(EUC_ROW_CELLS)
            + int'(code[7:0]) - int'(EUC_BASE);
        // skip absent glyph ranges below this code
        for (int k = 0; k < GAP_COUNT; k++) begin
            if (code >= GAP_FIRST[k]) begin
                if (code <= GAP_LAST[k]) return 1'b1;
                n -= int'(GAP_LAST[k]) - int'(GAP_FIRST[k]) + 1;
            end
        end
        if (n < 0 || n > int'(GLYPH_MAX)) return 1'b1;
        glyph = n[13:0];
        return 1'b0;
    endfunction

    // saturating pen advance
    function automatic void move_pen(input logic [3:0] step);
        int p;
        p = int'(pen_pos) + int'(step);
        pen_pos = (p > int'(PEN_CAP)) ? PEN_CAP : p[9:0];
    endfunction

    // decoder state update for one accepted byte
    function automatic void decode_sjis_byte(input text_byte_t tb_in);
        sgid_result_t r;
        logic [13:0]  glyph;
        if (tb_in.start) begin
            pen_pos = (tb_in.sx > PEN_CAP) ? PEN_CAP : tb_in.sx;
            lead_held = '0;
        end
        if (tb_in.text == END_OF_STRING) begin
            lead_held = '0;
            return;
        end
        if (lead_held != '0) begin
            r.missing_glyph = sjis_full_glyph(lead_held, tb_in.text, glyph);
            r.glyph_index = glyph;
            r.full_width = 1'b1;
            r.pen_x = pen_pos;
            glyph_q.push_back(r);
            lead_held = '0;
            move_pen(FULL_ADVANCE);
            return;
        end
        if ((tb_in.text >= LOW_LEAD_FIRST && tb_in.text < HALF_KANA_FIRST)
            || tb_in.text >= HIGH_LEAD_FIRST) begin
            lead_held = tb_in.text;
            return;
        end
        if (tb_in.text < HALF_PRINT_FIRST) r.glyph_index = '0;
        else if (tb_in.text < LOW_LEAD_FIRST)
            r.glyph_index = {6'd0, tb_in.text - PRINT_GLYPH_OFFSET};
        else if (tb_in.text < HALF_KANA_FIRST) r.glyph_index = '0;
        else r.glyph_index = {6'd0, tb_in.text - KANA_GLYPH_OFFSET};
        r.full_width = 1'b0;
        r.missing_glyph = 1'b0;
        r.pen_x = pen_pos;
        glyph_q.push_back(r);
        move_pen(HALF_ADVANCE);
    endfunction

    function automatic void add_byte(input logic [7:0] text, input logic start = 1'b0,
                                     input logic [9:0] sx = '0, input logic drain = 1'b0);
        text_byte_t t;
        t.text = text;
        t.start = start;
        t.sx = sx;
        t.drain = drain;
        text_q.push_back(t);
    endfunction

    function automatic logic [7:0] random_lead();
        if ($urandom_range(1)) return 8'($urandom_range(8'h9F, 8'h81));
        return 8'($urandom_range(8'hFF, HIGH_LEAD_FIRST));
    endfunction

    // input transaction driver
    always @(posedge aclk) begin : driver
        text_byte_t taken;
        text_byte_t nxt;
        logic       gap;
        if (!aresetn) begin
            s_valid <= 1'b0;
            lead_held = '0;
            pen_pos = '0;
        end else begin
            cycle_count <= cycle_count + 1;
            if (s_valid && s_ready) begin
                taken.text = s_text_byte;
                taken.start = s_string_start;
                taken.sx = s_start_x;
                taken.drain = 1'b0;
                decode_sjis_byte(taken);
            end
            gap = (cycle_count < QUIET_FIRST || cycle_count >= QUIET_LAST)
                  && ($urandom_range(99) < IDLE_PERCENT);
            if (!s_valid || s_ready) begin
                if (text_q.size() != 0 && !gap
                    && !(text_q[0].drain && glyph_q.size() != 0)) begin
                    nxt = text_q.pop_front();
                    s_valid <= 1'b1;
                    s_text_byte <= nxt.text;
                    s_string_start <= nxt.start;
                    s_start_x <= nxt.sx;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result transaction monitor
    always @(posedge aclk) begin : monitor
        sgid_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (glyph_q.size() == 0) begin
                    report_mismatch("unexpected transaction", 1, 0);
                end else begin
                    want = glyph_q.pop_front();
                    if (m_glyph_index != want.glyph_index)
                        report_mismatch("glyph_index", m_glyph_index, want.glyph_index);
                    if (m_full_width != want.full_width)
                        report_mismatch("full_width", m_full_width, want.full_width);
                    if (m_missing_glyph != want.missing_glyph)
                        report_mismatch("missing_glyph", m_missing_glyph, want.missing_glyph);
                    if (m_pen_x != want.pen_x)
                        report_mismatch("pen_x", m_pen_x, want.pen_x);
                end
            end
            m_ready <= !((cycle_count < QUIET_FIRST || cycle_count >= QUIET_LAST)
                         && ($urandom_range(99) < IDLE_PERCENT));
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        int         len;
        int         kind;
        logic       first;
        logic [9:0] sx;
        logic [7:0] trail;

        // directed corner cases
        add_byte(8'h41, 1'b1, 10'd0);
        add_byte(8'h01);
        add_byte(8'h1F);
        add_byte(8'h20);
        add_byte(8'h7F);
        add_byte(8'hA0);
        add_byte(8'hDF);
        add_byte(8'h81);
        add_byte(8'h40);
        add_byte(8'h81);
        add_byte(8'hAD);
        add_byte(8'hEA);
        add_byte(8'hA4);
        add_byte(8'hFF);
        add_byte(8'hFF);
        add_byte(8'h9F);
        add_byte(END_OF_STRING);
        add_byte(8'h88);
        add_byte(8'h41, 1'b1, 10'd1023);
        add_byte(8'hE0);
        add_byte(8'h40);
        add_byte(END_OF_STRING);
        add_byte(8'h41, 1'b1, 10'd1020, 1'b1);
        add_byte(8'h42);

        // random strings, mostly well formed, some noise
        while (text_q.size() < RANDOM_BYTES + 24) begin
            if ($urandom_range(99) < 80) begin
                sx = ($urandom_range(3) == 0) ? 10'($urandom_range(1023, 900))
                                              : 10'($urandom_range(1023));
                len = $urandom_range(12, 1);
                first = 1'b1;
                for (int i = 0; i < len; i++) begin
                    kind = $urandom_range(9);
                    if (kind < 3) begin
                        add_byte(8'($urandom_range(8'h7E, 8'h20)), first, sx,
                                 first && $urandom_range(49) == 0);
                    end else if (kind == 3) begin
                        add_byte(8'($urandom_range(8'h1F, 8'h01)), first, sx);
                    end else if (kind < 6) begin
                        add_byte(8'($urandom_range(8'hDF, 8'hA1)), first, sx);
                    end else begin
                        trail = 8'($urandom_range(TRAIL_LAST, TRAIL_FIRST));
                        if (trail == TRAIL_HOLE) trail = LOW_LEAD_FIRST;
                        if (kind == 9) trail = 8'($urandom_range(8'hFF, 8'h01));
                        add_byte(random_lead(), first, sx);
                        add_byte(trail);
                    end
                    first = 1'b0;
                end
                if ($urandom_range(9) != 0) add_byte(END_OF_STRING);
            end else begin
                len = $urandom_range(6, 1);
                for (int i = 0; i < len; i++)
                    add_byte(8'($urandom_range(255)), $urandom_range(7) == 0,
                             10'($urandom_range(1023)));
            end
        end

        while (text_q.size() != 0 || s_valid || glyph_q.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (error_count == 0 && glyph_q.size() == 0)
            $display("[sjis_glyph_index_decoder] OK");
        else
            $display("[sjis_glyph_index_decoder] ERROR");
        $finish;
    end

    // run limit
    initial begin
        #(12 * 200000);
        $display("[sjis_glyph_index_decoder] ERROR");
        $finish;
    end

endmodule
